### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is asserted
`define SLTM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that is also checked during reset
`define SLTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sltm_pkg.sv
// shared types and constants for the seqlock transaction manager
// no dependencies
package sltm_pkg;

  localparam int THREADS     = 8;
  localparam int TID_BITS    = 3;
  localparam int MEM_WORDS   = 256;
  localparam int ADDR_BITS   = 8;
  localparam int DATA_BITS   = 32;
  localparam int SEQ_BITS    = 32;
  localparam int CNT_BITS    = 32;
  localparam int MODE_BITS   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // operation codes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_COMMIT = 2'd3;

  // outcome codes
  localparam logic [2:0] OUT_OK        = 3'd0;
  localparam logic [2:0] OUT_RETRY     = 3'd1;
  localparam logic [2:0] OUT_ABORTED   = 3'd2;
  localparam logic [2:0] OUT_COMMITTED = 3'd3;
  localparam logic [2:0] OUT_INACTIVE  = 3'd4;

  // per-thread transaction mode
  localparam logic [MODE_BITS-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_ACTIVE  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_ABORTED = 2'd2;

  typedef struct packed {
    logic [TID_BITS-1:0]  thread;
    logic [1:0]           operation;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_BITS-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic [2:0]           outcome;
    logic [DATA_BITS-1:0] read_data;
    logic [CNT_BITS-1:0]  start_count;
    logic [CNT_BITS-1:0]  abort_count;
  } out_t;

  typedef struct packed {
    logic is_begin;
    logic is_load;
    logic is_store;
    logic is_commit;
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [TID_BITS-1:0]  thread;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_BITS-1:0] write_data;
  } req_t;

endpackage

### hw/rtl/sltm_front.sv
// front stage: takes input beats and decodes the operation
// depends on sltm_pkg
module sltm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sltm_pkg::in_t  in_data,
  input  logic           q_full,
  output logic           q_push,
  output sltm_pkg::req_t q_req
);

  logic           vld_r;
  sltm_pkg::req_t req_r;
  sltm_pkg::req_t dec;
  logic           take;

  always_comb begin
    dec            = '0;
    dec.thread     = in_data.thread;
    dec.address    = in_data.address;
    dec.write_data = in_data.write_data;
    unique case (in_data.operation)
      sltm_pkg::OP_BEGIN:  dec.kind.is_begin  = 1'b1;
      sltm_pkg::OP_LOAD:   dec.kind.is_load   = 1'b1;
      sltm_pkg::OP_STORE:  dec.kind.is_store  = 1'b1;
      sltm_pkg::OP_COMMIT: dec.kind.is_commit = 1'b1;
      default:             dec.kind.is_commit = 1'b1;
    endcase
  end

  assign in_stall = vld_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = vld_r && !q_full;
  assign q_req    = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      if (take) begin
        vld_r <= 1'b1;
      end else if (q_push) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= dec;
    end
  end

endmodule

### hw/rtl/sltm_queue.sv
// short request queue between front and back
// depends on sltm_pkg
module sltm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sltm_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           head_vld,
  output sltm_pkg::req_t head_req
);

  sltm_pkg::req_t                  slot_r [sltm_pkg::QUEUE_DEPTH];
  logic [sltm_pkg::QPTR_BITS-1:0]  wr_ptr_r;
  logic [sltm_pkg::QPTR_BITS-1:0]  rd_ptr_r;
  logic [sltm_pkg::QPTR_BITS:0]    count_r;
  logic                            do_push;
  logic                            do_pop;

  assign full     = (count_r == (sltm_pkg::QPTR_BITS+1)'(sltm_pkg::QUEUE_DEPTH));
  assign head_vld = (count_r != '0);
  assign head_req = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

### hw/rtl/sltm_back.sv
// back stage: sequence counter, per-thread state, shared memory and result register
// depends on sltm_pkg
module sltm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_vld,
  input  sltm_pkg::req_t q_req,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output sltm_pkg::out_t out_data
);

  typedef enum logic {S_EXEC, S_RESP} state_t;

  state_t                               state_r;
  logic                                 out_valid_r;
  sltm_pkg::out_t                       out_data_r;

  logic [sltm_pkg::SEQ_BITS-1:0]        seq_r;
  logic [sltm_pkg::SEQ_BITS-1:0]        snap_r   [sltm_pkg::THREADS];
  logic [sltm_pkg::MODE_BITS-1:0]       mode_r   [sltm_pkg::THREADS];
  logic [sltm_pkg::CNT_BITS-1:0]        starts_r [sltm_pkg::THREADS];
  logic [sltm_pkg::CNT_BITS-1:0]        aborts_r [sltm_pkg::THREADS];
  logic [sltm_pkg::THREADS-1:0]         has_read_r;
  logic [sltm_pkg::DATA_BITS-1:0]       mem_r    [sltm_pkg::MEM_WORDS];
  logic [sltm_pkg::MEM_WORDS-1:0]       mem_vld_r;

  // held between execute and response
  logic [2:0]                           outcome_r;
  logic                                 load_ok_r;
  logic [sltm_pkg::CNT_BITS-1:0]        start_cnt_r;
  logic [sltm_pkg::CNT_BITS-1:0]        abort_cnt_r;
  logic [sltm_pkg::DATA_BITS-1:0]       rd_data_r;
  logic                                 rd_vld_r;

  logic                                 exec;
  logic                                 resp_go;
  logic [sltm_pkg::TID_BITS-1:0]        t;
  logic [sltm_pkg::ADDR_BITS-1:0]       addr;
  logic [sltm_pkg::SEQ_BITS-1:0]        cur_snap;
  logic [sltm_pkg::SEQ_BITS-1:0]        snap_inc;
  logic                                 active;
  logic                                 match;
  logic                                 snap_even;

  logic [sltm_pkg::SEQ_BITS-1:0]        seq_nxt;
  logic [sltm_pkg::SEQ_BITS-1:0]        snap_nxt;
  logic [sltm_pkg::MODE_BITS-1:0]       mode_nxt;
  logic [sltm_pkg::CNT_BITS-1:0]        starts_nxt;
  logic [sltm_pkg::CNT_BITS-1:0]        aborts_nxt;
  logic                                 has_read_nxt;
  logic [2:0]                           outcome_nxt;
  logic                                 load_ok_nxt;
  logic                                 do_write;

  assign exec      = (state_r == S_EXEC) && q_vld;
  assign q_pop     = exec;
  assign resp_go   = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign t         = q_req.thread;
  assign addr      = q_req.address;
  assign cur_snap  = snap_r[t];
  assign snap_inc  = cur_snap + 1'b1;
  assign active    = (mode_r[t] == sltm_pkg::MODE_ACTIVE);
  assign match     = (seq_r == cur_snap);
  assign snap_even = !cur_snap[0];

  always_comb begin
    seq_nxt      = seq_r;
    snap_nxt     = cur_snap;
    mode_nxt     = mode_r[t];
    starts_nxt   = starts_r[t];
    aborts_nxt   = aborts_r[t];
    has_read_nxt = has_read_r[t];
    outcome_nxt  = sltm_pkg::OUT_OK;
    load_ok_nxt  = 1'b0;
    do_write     = 1'b0;
    priority if (q_req.kind.is_begin) begin
      has_read_nxt = 1'b0;
      if (seq_r[0]) begin
        snap_nxt    = '0;
        mode_nxt    = sltm_pkg::MODE_IDLE;
        outcome_nxt = sltm_pkg::OUT_RETRY;
      end else begin
        snap_nxt   = seq_r;
        starts_nxt = starts_r[t] + 1'b1;
        mode_nxt   = sltm_pkg::MODE_ACTIVE;
      end
    end else if (q_req.kind.is_load) begin
      if (!active) begin
        outcome_nxt = sltm_pkg::OUT_INACTIVE;
      end else if (match) begin
        load_ok_nxt = 1'b1;
        if (snap_even) begin
          has_read_nxt = 1'b1;
        end
      end else begin
        mode_nxt    = sltm_pkg::MODE_ABORTED;
        aborts_nxt  = aborts_r[t] + 1'b1;
        outcome_nxt = sltm_pkg::OUT_ABORTED;
      end
    end else if (q_req.kind.is_store) begin
      if (!active) begin
        aborts_nxt  = aborts_r[t] + 1'b1;
        outcome_nxt = sltm_pkg::OUT_ABORTED;
      end else if (!snap_even) begin
        do_write = 1'b1;
      end else if (match) begin
        // first store takes the writer role
        seq_nxt  = snap_inc;
        snap_nxt = snap_inc;
        do_write = 1'b1;
      end else begin
        mode_nxt    = sltm_pkg::MODE_ABORTED;
        aborts_nxt  = aborts_r[t] + 1'b1;
        outcome_nxt = sltm_pkg::OUT_ABORTED;
      end
    end else begin
      if (!active) begin
        outcome_nxt = sltm_pkg::OUT_INACTIVE;
      end else begin
        if (!snap_even) begin
          seq_nxt = snap_inc;
        end
        mode_nxt     = sltm_pkg::MODE_IDLE;
        has_read_nxt = 1'b0;
        outcome_nxt  = sltm_pkg::OUT_COMMITTED;
      end
    end
  end

  // fsm and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_EXEC: begin
          if (exec) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (resp_go) begin
            state_r <= S_EXEC;
          end
        end
        default: state_r <= S_EXEC;
      endcase
      if (resp_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (exec) begin
      outcome_r   <= outcome_nxt;
      load_ok_r   <= load_ok_nxt;
      start_cnt_r <= starts_nxt;
      abort_cnt_r <= aborts_nxt;
      rd_vld_r    <= mem_vld_r[addr];
    end
    if (resp_go) begin
      out_data_r.outcome     <= outcome_r;
      out_data_r.read_data   <= (load_ok_r && rd_vld_r) ? rd_data_r : '0;
      out_data_r.start_count <= start_cnt_r;
      out_data_r.abort_count <= abort_cnt_r;
    end
  end

  // sequence counter and per-thread records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= '0;
      has_read_r <= '0;
      mem_vld_r  <= '0;
      for (int i = 0; i < sltm_pkg::THREADS; i++) begin
        snap_r[i]   <= '0;
        mode_r[i]   <= sltm_pkg::MODE_IDLE;
        starts_r[i] <= '0;
        aborts_r[i] <= '0;
      end
    end else if (exec) begin
      seq_r         <= seq_nxt;
      snap_r[t]     <= snap_nxt;
      mode_r[t]     <= mode_nxt;
      starts_r[t]   <= starts_nxt;
      aborts_r[t]   <= aborts_nxt;
      has_read_r[t] <= has_read_nxt;
      if (do_write) begin
        mem_vld_r[addr] <= 1'b1;
      end
    end
  end

  // shared data memory, registered read
  always_ff @(posedge clk) begin
    if (exec) begin
      rd_data_r <= mem_r[addr];
      if (do_write) begin
        mem_r[addr] <= q_req.write_data;
      end
    end
  end

endmodule

### hw/rtl/seqlock_transaction_manager.sv
// top level of the seqlock transaction manager
// depends on sltm_pkg, sltm_front, sltm_queue and sltm_back
//
// usage
//   in_valid/in_stall/in_data carry request beats (thread, operation, address,
//   write data); out_valid/out_stall/out_data carry one result beat for every
//   request, in request order. a beat moves when valid is high and stall low
//   a request passes through the front register, the queue, the execute step
//   and the response register; the back end handles one request at a time
//   (execute with the memory read, then forming the result from the registered
//   read data) and takes no new request until that result has moved into the
//   response register
//   the front register and a two-entry queue keep accepting requests while a
//   result waits on out_stall; once both are full in_stall rises
//   a held result keeps its data until it is taken
//   reset clears the sequence counter, all per-thread records and the
//   per-word valid bits of the shared memory, so every word reads as zero
//   until written; no clearing pass is needed
module seqlock_transaction_manager (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sltm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sltm_pkg::out_t out_data
);

  // front to queue
  logic           fq_push;
  logic           fq_full;
  sltm_pkg::req_t fq_req;

  // queue to back
  logic           qb_vld;
  logic           qb_pop;
  sltm_pkg::req_t qb_req;

  // decode and hold each request beat
  sltm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (fq_full),
    .q_push   (fq_push),
    .q_req    (fq_req)
  );

  // decouples the front from a stalled back end
  sltm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .push_req (fq_req),
    .full     (fq_full),
    .pop      (qb_pop),
    .head_vld (qb_vld),
    .head_req (qb_req)
  );

  // carries out begin, load, store and commit one at a time
  sltm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (qb_vld),
    .q_req     (qb_req),
    .q_pop     (qb_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/sltm_checker.sv
// port-level checks on the result channel, bound to the top level
// depends on sltm_pkg and assert_macros.svh
`include "assert_macros.svh"

module sltm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input sltm_pkg::out_t out_data
);

  `SLTM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")
  `SLTM_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `SLTM_ASSERT(a_outcome_code, clk, rst_n, out_valid |-> out_data.outcome <= sltm_pkg::OUT_INACTIVE, "outcome code out of range")
  `SLTM_ASSERT(a_rdata_zero, clk, rst_n, out_valid && (out_data.outcome != sltm_pkg::OUT_OK) |-> out_data.read_data == '0, "read data on a failed request")
  `SLTM_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind seqlock_transaction_manager sltm_checker u_sltm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/tb_top.sv
// self-checking testbench for seqlock_transaction_manager: directed and random request beats
// depends on sltm_pkg and the seqlock_transaction_manager rtl
`timescale 1ns / 100ps

module tb_top;

  // request queued for the driver, optionally held back until the block has drained
  typedef struct {
    sltm_pkg::in_t beat;
    bit            drain_first;
  } req_item_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  sltm_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  sltm_pkg::out_t out_data;

  seqlock_transaction_manager dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // predicted state of the lock manager
  logic [sltm_pkg::SEQ_BITS-1:0]  counter_now;
  logic [sltm_pkg::SEQ_BITS-1:0]  snap_of   [sltm_pkg::THREADS];
  logic                           read_seen [sltm_pkg::THREADS];
  logic [sltm_pkg::MODE_BITS-1:0] mode_of   [sltm_pkg::THREADS];
  logic [sltm_pkg::CNT_BITS-1:0]  starts_of [sltm_pkg::THREADS];
  logic [sltm_pkg::CNT_BITS-1:0]  aborts_of [sltm_pkg::THREADS];
  logic [sltm_pkg::DATA_BITS-1:0] word_mem  [sltm_pkg::MEM_WORDS];

  req_item_t      send_q[$];
  sltm_pkg::out_t pending_results[$];

  bit          in_took = 1'b0;
  bit          out_took = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit          in_rush = 1'b0;
  bit          out_rush = 1'b0;

  int unsigned fault_count = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_drains = 0;
  int unsigned seen_outcome[5];

  // applies one request to the predicted state and returns the result beat it must give
  function automatic sltm_pkg::out_t seqlock_apply(sltm_pkg::in_t req);
    sltm_pkg::out_t                res;
    logic [sltm_pkg::TID_BITS-1:0] t;
    logic [sltm_pkg::SEQ_BITS-1:0] s;
    res = '0;
    t = req.thread;
    s = snap_of[t];
    case (req.operation)
      sltm_pkg::OP_BEGIN: begin
        read_seen[t] = 1'b0;
        snap_of[t] = '0;
        // an odd counter means a writer holds the lock
        if (counter_now[0]) begin
          mode_of[t] = sltm_pkg::MODE_IDLE;
          res.outcome = sltm_pkg::OUT_RETRY;
        end else begin
          snap_of[t] = counter_now;
          starts_of[t] = starts_of[t] + 1'b1;
          mode_of[t] = sltm_pkg::MODE_ACTIVE;
          res.outcome = sltm_pkg::OUT_OK;
        end
      end
      sltm_pkg::OP_LOAD: begin
        if (mode_of[t] != sltm_pkg::MODE_ACTIVE) begin
          res.outcome = sltm_pkg::OUT_INACTIVE;
        end else if (counter_now == s) begin
          if (!s[0]) read_seen[t] = 1'b1;
          res.read_data = word_mem[req.address];
          res.outcome = sltm_pkg::OUT_OK;
        end else begin
          mode_of[t] = sltm_pkg::MODE_ABORTED;
          aborts_of[t] = aborts_of[t] + 1'b1;
          res.outcome = sltm_pkg::OUT_ABORTED;
        end
      end
      sltm_pkg::OP_STORE: begin
        if (mode_of[t] != sltm_pkg::MODE_ACTIVE) begin
          // counted as an abort, mode left alone
          aborts_of[t] = aborts_of[t] + 1'b1;
          res.outcome = sltm_pkg::OUT_ABORTED;
        end else if (s[0] || counter_now == s) begin
          // first store takes the writer role by making the counter odd
          if (!s[0]) begin
            counter_now = s + 1'b1;
            snap_of[t] = s + 1'b1;
          end
          word_mem[req.address] = req.write_data;
          res.outcome = sltm_pkg::OUT_OK;
        end else begin
          // lost the compare step: no write
          mode_of[t] = sltm_pkg::MODE_ABORTED;
          aborts_of[t] = aborts_of[t] + 1'b1;
          res.outcome = sltm_pkg::OUT_ABORTED;
        end
      end
      default: begin
        if (mode_of[t] != sltm_pkg::MODE_ACTIVE) begin
          res.outcome = sltm_pkg::OUT_INACTIVE;
        end else begin
          if (s[0]) counter_now = s + 1'b1;
          mode_of[t] = sltm_pkg::MODE_IDLE;
          read_seen[t] = 1'b0;
          res.outcome = sltm_pkg::OUT_COMMITTED;
        end
      end
    endcase
    res.start_count = starts_of[t];
    res.abort_count = aborts_of[t];
    return res;
  endfunction

  task automatic note_fault(string what, logic [31:0] want_v, logic [31:0] got_v);
    fault_count++;
    if (fault_count <= 10)
      $display("result %0d: %s expected %h, got %h", n_results, what, want_v, got_v);
  endtask

  task automatic queue_req(int t, logic [1:0] op, int addr, logic [31:0] wd, bit drain);
    req_item_t it;
    it.beat.thread = sltm_pkg::TID_BITS'(t);
    it.beat.operation = op;
    it.beat.address = sltm_pkg::ADDR_BITS'(addr);
    it.beat.write_data = wd;
    it.drain_first = drain;
    send_q.push_back(it);
  endtask

  // monitor: sample both handshakes at the rising edge, predict then check
  always @(posedge clk) begin
    sltm_pkg::out_t want;
    sltm_pkg::out_t got;
    if (rst_n && in_valid && !in_stall) begin
      pending_results.push_back(seqlock_apply(in_data));
      n_requests++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      n_results++;
      if (got.outcome <= sltm_pkg::OUT_INACTIVE) seen_outcome[got.outcome]++;
      if (pending_results.size() == 0) begin
        note_fault("unrequested result beat, outcome", '0, 32'(got.outcome));
      end else begin
        want = pending_results.pop_front();
        if (got.outcome !== want.outcome)
          note_fault("outcome", 32'(want.outcome), 32'(got.outcome));
        if (got.read_data !== want.read_data)
          note_fault("read_data", want.read_data, got.read_data);
        if (got.start_count !== want.start_count)
          note_fault("start_count", want.start_count, got.start_count);
        if (got.abort_count !== want.abort_count)
          note_fault("abort_count", want.abort_count, got.abort_count);
      end
    end
    in_took <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
  end

  // driver: request beats change on the falling edge, one assignment per signal
  always @(negedge clk) begin
    logic          nv;
    sltm_pkg::in_t nd;
    bit            busy;
    nv = in_valid;
    nd = in_data;
    busy = in_valid && !in_took;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!busy) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (send_q.size() != 0 &&
                   !(send_q[0].drain_first && pending_results.size() != 0)) begin
        // a drain-marked beat waits until every result is back
        if (send_q[0].drain_first) n_drains++;
        nd = send_q[0].beat;
        nv = 1'b1;
        void'(send_q.pop_front());
        in_gap = in_rush ? 0 : $urandom_range(0, 14);
        // occasional back-to-back stretches
        if ($urandom_range(0, 59) == 0) in_rush = !in_rush;
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // result side back-pressure: a fresh stall length after every taken beat
  always @(negedge clk) begin
    if (out_took) begin
      out_hold = out_rush ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 59) == 0) out_rush = !out_rush;
    end
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // stimulus, reset and end of run
  initial begin
    bit          open_tx[sltm_pkg::THREADS];
    int          t;
    int          n;
    int          roll;
    int          addr;
    logic [1:0]  op;
    logic [31:0] wd;
    counter_now = '0;
    for (int i = 0; i < sltm_pkg::THREADS; i++) begin
      snap_of[i] = '0;
      read_seen[i] = 1'b0;
      mode_of[i] = sltm_pkg::MODE_IDLE;
      starts_of[i] = '0;
      aborts_of[i] = '0;
      open_tx[i] = 1'b0;
    end
    for (int i = 0; i < sltm_pkg::MEM_WORDS; i++) word_mem[i] = '0;
    for (int i = 0; i < 5; i++) seen_outcome[i] = 0;

    // directed: requests on an idle thread
    queue_req(0, sltm_pkg::OP_LOAD, 0, 32'h0, 1'b0);
    queue_req(0, sltm_pkg::OP_COMMIT, 0, 32'h0, 1'b0);
    queue_req(0, sltm_pkg::OP_STORE, 3, 32'h0, 1'b0);
    // writer transaction at the address extremes
    queue_req(0, sltm_pkg::OP_BEGIN, 0, 32'h0, 1'b0);
    queue_req(0, sltm_pkg::OP_LOAD, 0, 32'h0, 1'b0);
    queue_req(0, sltm_pkg::OP_STORE, 255, 32'hffff_ffff, 1'b0);
    queue_req(0, sltm_pkg::OP_STORE, 0, 32'h0, 1'b0);
    queue_req(0, sltm_pkg::OP_LOAD, 255, 32'h0, 1'b0);
    // begin while the counter is odd, then load with nothing started
    queue_req(1, sltm_pkg::OP_BEGIN, 0, 32'h0, 1'b0);
    queue_req(1, sltm_pkg::OP_LOAD, 0, 32'h0, 1'b0);
    queue_req(0, sltm_pkg::OP_COMMIT, 0, 32'h0, 1'b0);
    // reader invalidated by another writer
    queue_req(1, sltm_pkg::OP_BEGIN, 0, 32'h0, 1'b0);
    queue_req(1, sltm_pkg::OP_LOAD, 255, 32'h0, 1'b0);
    queue_req(2, sltm_pkg::OP_BEGIN, 0, 32'h0, 1'b0);
    queue_req(2, sltm_pkg::OP_STORE, 7, 32'h1234_5678, 1'b0);
    queue_req(1, sltm_pkg::OP_LOAD, 7, 32'h0, 1'b0);
    queue_req(1, sltm_pkg::OP_STORE, 7, 32'hdead_beef, 1'b0);
    queue_req(2, sltm_pkg::OP_COMMIT, 0, 32'h0, 1'b0);
    // two would-be writers on the same snapshot, the loser must not write
    queue_req(3, sltm_pkg::OP_BEGIN, 0, 32'h0, 1'b0);
    queue_req(4, sltm_pkg::OP_BEGIN, 0, 32'h0, 1'b0);
    queue_req(3, sltm_pkg::OP_STORE, 128, 32'ha5a5_a5a5, 1'b0);
    queue_req(4, sltm_pkg::OP_STORE, 129, 32'h5a5a_5a5a, 1'b0);
    queue_req(4, sltm_pkg::OP_COMMIT, 0, 32'h0, 1'b0);
    queue_req(3, sltm_pkg::OP_COMMIT, 0, 32'h0, 1'b0);
    // read-only transaction on the top thread, commit leaves the counter even
    queue_req(7, sltm_pkg::OP_BEGIN, 0, 32'h0, 1'b0);
    queue_req(7, sltm_pkg::OP_LOAD, 129, 32'h0, 1'b0);
    queue_req(7, sltm_pkg::OP_LOAD, 128, 32'h0, 1'b0);
    queue_req(7, sltm_pkg::OP_COMMIT, 0, 32'h0, 1'b0);

    // random: mostly well-formed transactions from interleaved threads, some noise
    t = 0;
    for (n = 0; n < 1250; n++) begin
      if ($urandom_range(0, 9) < 4) t = $urandom_range(0, sltm_pkg::THREADS - 1);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        op = 2'($urandom_range(0, 3));
        if (op == sltm_pkg::OP_BEGIN) open_tx[t] = 1'b1;
        if (op == sltm_pkg::OP_COMMIT) open_tx[t] = 1'b0;
      end else if (!open_tx[t]) begin
        op = sltm_pkg::OP_BEGIN;
        open_tx[t] = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          op = sltm_pkg::OP_LOAD;
        end else if (roll < 75) begin
          op = sltm_pkg::OP_STORE;
        end else begin
          op = sltm_pkg::OP_COMMIT;
          open_tx[t] = 1'b0;
        end
      end
      // a small hot set of words so loads see earlier stores
      addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      case ($urandom_range(0, 15))
        0:       wd = 32'h0;
        1:       wd = 32'hffff_ffff;
        default: wd = $urandom;
      endcase
      queue_req(t, op, addr, wd, (n == 0) || ($urandom_range(0, 199) == 0));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (send_q.size() != 0 || in_valid || pending_results.size() != 0) @(posedge clk);
    // extra wait past the pipeline depth to catch stray beats
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0)
      note_fault("results still owed, count", '0, pending_results.size());

    $display("covered %0d requests and %0d result beats: %0d ok, %0d retry, %0d aborted,",
             n_requests, n_results, seen_outcome[sltm_pkg::OUT_OK],
             seen_outcome[sltm_pkg::OUT_RETRY], seen_outcome[sltm_pkg::OUT_ABORTED]);
    $display("%0d committed, %0d not active; sender drained the block %0d times",
             seen_outcome[sltm_pkg::OUT_COMMITTED], seen_outcome[sltm_pkg::OUT_INACTIVE],
             n_drains);
    if (fault_count == 0) begin
      $display("seqlock_transaction_manager verification clean");
    end else begin
      $display("%0d mismatches in total", fault_count);
      $display("seqlock_transaction_manager verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("seqlock_transaction_manager verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sltm_pkg.sv
hw/rtl/sltm_front.sv
hw/rtl/sltm_queue.sv
hw/rtl/sltm_back.sv
hw/rtl/seqlock_transaction_manager.sv
hw/rtl/sltm_checker.sv
dv/tb_top.sv
